### rtl/atp_pkg.sv
// Shared types and constants for the polynomial atan2 pipeline.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package atp_pkg;

	// Horner accumulator: signed, 30 fraction bits, range beyond +/-pi
	localparam int ACC_W    = 34;
	localparam int ACC_FRAC = 30;
	localparam int ANGLE_W  = 16;
	localparam int OUT_FRAC = 13;
	localparam int OUT_SHIFT = ACC_FRAC - OUT_FRAC;
	localparam int NUM_COEF = 7;

	localparam logic signed [ACC_W-1:0] PI_ACC      = 34'sd3373259426;
	localparam logic signed [ACC_W-1:0] HALF_PI_ACC = 34'sd1686629713;

	// Minimax coefficients, highest power first, Q30
	localparam logic signed [ACC_W-1:0] POLY_COEF [NUM_COEF] = '{
		34'sd7744777,
		-34'sd37645046,
		34'sd87698811,
		-34'sd143609290,
		34'sd213208227,
		-34'sd357824448,
		34'sd1073741824
	};

	// Octant and special-case flags that ride along with an item
	typedef struct packed {
		logic zero;
		logic swap;
		logic xneg;
		logic yneg;
	} octant_t;

endpackage
`default_nettype wire

### rtl/atan2_polynomial_approx.sv
// Channel | dir | tdata bits (low first)              | handshake
// s_axis  | in  | y_value[IN_WIDTH], x_value[IN_WIDTH] | tvalid/tready
// m_axis  | out | angle[16], signed Q2.13 radians      | tvalid/tready
//
// One item per clock while the output register is not stalled. The angle passes
// through RATIO_FRAC_BITS + 20 register stages: input stage, one-bit-per-stage
// divider (RATIO_FRAC_BITS + 1 stages), two squaring stages, seven two-stage
// multiply steps, reflection and output register.
// Reset clears only the valid bits. When the output register holds an
// unaccepted item the whole pipeline stalls and nothing is lost.
// Top level of the atan2 pipeline; depends on atp_pkg, atp_div and atp_mac.
`timescale 1ns / 1ps
`default_nettype none
module atan2_polynomial_approx #(
	parameter int IN_WIDTH        = 16,
	parameter int RATIO_FRAC_BITS = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// y_value [IN_WIDTH-1:0], x_value [2*IN_WIDTH-1:IN_WIDTH], zero fill
	input  wire  [((2*IN_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready,
	// angle [15:0]
	output logic [atp_pkg::ANGLE_W-1:0]           m_axis_tdata
);
	import atp_pkg::*;

	localparam int W   = IN_WIDTH;
	localparam int F   = RATIO_FRAC_BITS;
	localparam int Q_W = F + 1;
	localparam logic [2*Q_W-1:0] R2_HALF = {{(2*Q_W-1){1'b0}}, 1'b1} << (F - 1);
	localparam logic [ACC_W-1:0] OUT_HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (OUT_SHIFT - 1);

	logic en;

	logic [W-1:0] y_raw, x_raw, y_mag, x_mag;
	logic         y_neg, x_neg, swap;

	logic         vld_s1;
	logic [W-1:0] small_s1, big_s1;
	octant_t      flags_s1;

	logic         div_vld;
	logic [Q_W-1:0] div_q;
	octant_t      div_flags;

	logic           vld_s2, vld_s3;
	logic [2*Q_W-1:0] rsq_s2;
	logic [Q_W-1:0] r_s2, r_s3, r2_s3;
	octant_t        flags_s2, flags_s3;

	logic                    mac_vld   [NUM_COEF];
	logic signed [ACC_W-1:0] mac_acc   [NUM_COEF];
	logic [Q_W-1:0]          mac_r     [NUM_COEF];
	logic [Q_W-1:0]          mac_r2    [NUM_COEF];
	octant_t                 mac_flags [NUM_COEF];

	logic                    vld_s4;
	logic signed [ACC_W-1:0] refl_a, refl_b, refl_c, angle_s4;
	logic                    zero_s4;
	logic                    out_neg;
	logic [ACC_W-1:0]        out_mag, out_sh;
	logic signed [ACC_W-1:0] out_full;
	logic                    out_vld_q;
	logic [ANGLE_W-1:0]      out_angle_q;

	// Advance everything while the output register is free or being drained
	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// Take magnitudes and order them
	always_comb begin
		y_raw = s_axis_tdata[W-1:0];
		x_raw = s_axis_tdata[2*W-1:W];
		y_neg = y_raw[W-1];
		x_neg = x_raw[W-1];
		y_mag = y_neg ? W'(~y_raw + 1'b1) : y_raw;
		x_mag = x_neg ? W'(~x_raw + 1'b1) : x_raw;
		swap  = (y_mag > x_mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= s_axis_tvalid;
			vld_s2    <= div_vld;
			vld_s3    <= vld_s2;
			vld_s4    <= mac_vld[NUM_COEF-1];
			out_vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			small_s1      <= swap ? x_mag : y_mag;
			big_s1        <= swap ? y_mag : x_mag;
			flags_s1.zero <= (y_mag == '0) && (x_mag == '0);
			flags_s1.swap <= swap;
			flags_s1.xneg <= x_neg;
			flags_s1.yneg <= y_neg;
		end
	end

	atp_div #(
		.MAG_W (W),
		.Q_W   (Q_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (vld_s1),
		.small_mag (small_s1),
		.big_mag   (big_s1),
		.in_flags  (flags_s1),
		.out_vld   (div_vld),
		.quot      (div_q),
		.out_flags (div_flags)
	);

	// Square the ratio, then round it back to the ratio format
	always_ff @(posedge clk) begin
		if (en) begin
			rsq_s2   <= (2*Q_W)'(div_q) * (2*Q_W)'(div_q);
			r_s2     <= div_q;
			flags_s2 <= div_flags;
			r2_s3    <= Q_W'((rsq_s2 + R2_HALF) >> F);
			r_s3     <= r_s2;
			flags_s3 <= flags_s2;
		end
	end

	// Horner chain over r^2, closing with one multiply by r
	genvar k;
	generate
		for (k = 0; k < NUM_COEF; k++) begin : g_horner
			atp_mac #(
				.Q_W   (Q_W),
				.FRAC  (F),
				.USE_R (k == NUM_COEF - 1),
				.COEF  ((k < NUM_COEF - 1) ? POLY_COEF[(k + 1) % NUM_COEF] : '0)
			) u_mac (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_vld    ((k == 0) ? vld_s3   : mac_vld[(k + NUM_COEF - 1) % NUM_COEF]),
				.acc_in    ((k == 0) ? POLY_COEF[0] : mac_acc[(k + NUM_COEF - 1) % NUM_COEF]),
				.r_in      ((k == 0) ? r_s3     : mac_r[(k + NUM_COEF - 1) % NUM_COEF]),
				.r2_in     ((k == 0) ? r2_s3    : mac_r2[(k + NUM_COEF - 1) % NUM_COEF]),
				.in_flags  ((k == 0) ? flags_s3 : mac_flags[(k + NUM_COEF - 1) % NUM_COEF]),
				.out_vld   (mac_vld[k]),
				.acc_out   (mac_acc[k]),
				.r_out     (mac_r[k]),
				.r2_out    (mac_r2[k]),
				.out_flags (mac_flags[k])
			);
		end
	endgenerate

	// Reflect the first-octant angle into its octant and quadrant
	always_comb begin
		refl_a = mac_flags[NUM_COEF-1].swap ? HALF_PI_ACC - mac_acc[NUM_COEF-1]
		                                    : mac_acc[NUM_COEF-1];
		refl_b = mac_flags[NUM_COEF-1].xneg ? PI_ACC - refl_a : refl_a;
		refl_c = mac_flags[NUM_COEF-1].yneg ? -refl_b : refl_b;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s4 <= refl_c;
			zero_s4  <= mac_flags[NUM_COEF-1].zero;
		end
	end

	// Round to Q2.13, ties away from zero
	always_comb begin
		out_neg  = angle_s4[ACC_W-1];
		out_mag  = out_neg ? ACC_W'(-angle_s4) : angle_s4;
		out_sh   = (out_mag + OUT_HALF) >> OUT_SHIFT;
		out_full = out_neg ? -$signed(out_sh) : $signed(out_sh);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_angle_q <= zero_s4 ? '0 : out_full[ANGLE_W-1:0];
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_angle_q;

`ifndef SYNTH
	// A stalled item stays in the output register
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output item dropped or changed under stall");

	// Input is taken exactly when the output side can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready out of step with output stall");

	// Angle stays within -pi..pi
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata) <= 16'sd25736) &&
		                  ($signed(m_axis_tdata) >= -16'sd25736))
		else $error("angle outside -pi..pi");
`endif

endmodule
`default_nettype wire

### rtl/atp_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on atp_pkg for the octant flag type.
`timescale 1ns / 1ps
`default_nettype none
module atp_div #(
	parameter int MAG_W = 16,
	parameter int Q_W   = 17
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      en,
	input  wire                      in_vld,
	input  wire  [MAG_W-1:0]         small_mag,
	input  wire  [MAG_W-1:0]         big_mag,
	input  atp_pkg::octant_t         in_flags,
	output logic                     out_vld,
	output logic [Q_W-1:0]           quot,
	output atp_pkg::octant_t         out_flags
);
	import atp_pkg::*;

	logic             vld_s   [Q_W];
	logic [MAG_W-1:0] rem_s   [Q_W];
	logic [MAG_W-1:0] big_s   [Q_W];
	logic [Q_W-1:0]   q_s     [Q_W];
	octant_t          flags_s [Q_W];

	genvar i;
	generate
		for (i = 0; i < Q_W; i++) begin : g_stage
			logic [MAG_W:0]   partial;
			logic [MAG_W-1:0] big_in;
			logic [Q_W-1:0]   q_in;
			logic             vld_in;
			octant_t          flags_in;
			logic             qbit;

			// Take the previous remainder, doubled, or the dividend in stage zero
			if (i == 0) begin : g_first
				assign partial  = {1'b0, small_mag};
				assign big_in   = big_mag;
				assign q_in     = '0;
				assign vld_in   = in_vld;
				assign flags_in = in_flags;
			end else begin : g_next
				assign partial  = {rem_s[i-1], 1'b0};
				assign big_in   = big_s[i-1];
				assign q_in     = q_s[i-1];
				assign vld_in   = vld_s[i-1];
				assign flags_in = flags_s[i-1];
			end

			assign qbit = (partial >= {1'b0, big_in});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[i] <= 1'b0;
				end else if (en) begin
					vld_s[i] <= vld_in;
				end
			end

			// Subtract the divisor where it fits and shift in the quotient bit
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i]   <= qbit ? MAG_W'(partial - {1'b0, big_in})
					                   : partial[MAG_W-1:0];
					big_s[i]   <= big_in;
					q_s[i]     <= {q_in[Q_W-2:0], qbit};
					flags_s[i] <= flags_in;
				end
			end
		end
	endgenerate

	assign out_vld   = vld_s[Q_W-1];
	assign quot      = q_s[Q_W-1];
	assign out_flags = flags_s[Q_W-1];

endmodule
`default_nettype wire

### rtl/atp_mac.sv
// One Horner step over two stages: multiply, then round and add a coefficient.
// Depends on atp_pkg for accumulator width and the octant flag type.
`timescale 1ns / 1ps
`default_nettype none
module atp_mac #(
	parameter int Q_W    = 17,
	parameter int FRAC   = 16,
	parameter bit USE_R  = 1'b0,
	parameter logic signed [atp_pkg::ACC_W-1:0] COEF = '0
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 en,
	input  wire                                 in_vld,
	input  wire  signed [atp_pkg::ACC_W-1:0]    acc_in,
	input  wire  [Q_W-1:0]                      r_in,
	input  wire  [Q_W-1:0]                      r2_in,
	input  atp_pkg::octant_t                    in_flags,
	output logic                                out_vld,
	output logic signed [atp_pkg::ACC_W-1:0]    acc_out,
	output logic [Q_W-1:0]                      r_out,
	output logic [Q_W-1:0]                      r2_out,
	output atp_pkg::octant_t                    out_flags
);
	import atp_pkg::*;

	localparam int PW = ACC_W + Q_W + 1;
	localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (FRAC - 1);

	logic                 vld_s1, vld_s2;
	logic signed [PW-1:0] prod_s1;
	logic [Q_W-1:0]       r_s1, r2_s1;
	octant_t              flags_s1;
	logic signed [Q_W:0]  mult;
	logic                 neg;
	logic [PW-1:0]        mag, shifted;
	logic signed [PW-1:0] rounded;

	assign mult = $signed({1'b0, (USE_R ? r_in : r2_in)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	// Stage one: register the product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= PW'(acc_in) * PW'(mult);
			r_s1     <= r_in;
			r2_s1    <= r2_in;
			flags_s1 <= in_flags;
		end
	end

	// Round to nearest, ties away from zero, on the magnitude
	always_comb begin
		neg     = prod_s1[PW-1];
		mag     = neg ? PW'(-prod_s1) : prod_s1;
		shifted = (mag + HALF) >> FRAC;
		rounded = neg ? -$signed(shifted) : $signed(shifted);
	end

	// Stage two: add the next coefficient
	always_ff @(posedge clk) begin
		if (en) begin
			acc_out   <= ACC_W'(rounded) + COEF;
			r_out     <= r_s1;
			r2_out    <= r2_s1;
			out_flags <= flags_s1;
		end
	end

	assign out_vld = vld_s2;

endmodule
`default_nettype wire

### tb/atan2_polynomial_approx_tb.sv
// Self-checking bench for the polynomial atan2 pipeline: random and corner
// coordinate pairs, an in-bench angle predictor, random stalls on both sides.
// Depends on atp_pkg and atan2_polynomial_approx.
`timescale 1ns / 1ps
module atan2_polynomial_approx_tb;
	import atp_pkg::*;

	localparam int FRAC = 16;
	localparam int LATENCY = FRAC + 19;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// y_value [15:0], x_value [31:16]
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// angle [15:0]
	logic [15:0] m_axis_tdata;

	logic [31:0] pending_pairs[$];
	logic [15:0] expected_angles[$];
	int mismatches = 0;
	longint cycles = 0;
	bit calm = 0;      // no idling on either side
	int hold_off = 0;  // receiver long stall counter

	atan2_polynomial_approx dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint round_shr(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0) return (v + half) >>> s;
		return -((-v + half) >>> s);
	endfunction

	// Predict the Q2.13 angle of one coordinate pair
	function automatic logic [15:0] predict_angle(logic [31:0] pair);
		logic signed [15:0] y, x;
		longint ymag, xmag, big, lesser, r, r2, acc;
		bit swap;
		y = pair[15:0];
		x = pair[31:16];
		ymag = y < 0 ? -longint'(y) : longint'(y);
		xmag = x < 0 ? -longint'(x) : longint'(x);
		swap = ymag > xmag;
		big = swap ? ymag : xmag;
		lesser = swap ? xmag : ymag;
		if (big == 0) return '0;
		r = (lesser << FRAC) / big;
		r2 = (r * r + (longint'(1) << (FRAC - 1))) >> FRAC;
		acc = longint'(POLY_COEF[0]);
		for (int k = 1; k < NUM_COEF; k++)
			acc = round_shr(acc * r2, FRAC) + longint'(POLY_COEF[k]);
		acc = round_shr(acc * r, FRAC);
		if (swap) acc = longint'(HALF_PI_ACC) - acc;
		if (x < 0) acc = longint'(PI_ACC) - acc;
		if (y < 0) acc = -acc;
		acc = round_shr(acc, OUT_SHIFT);
		return acc[15:0];
	endfunction

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 7)) - 16'd3;
			1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	// Record each accepted item and predict its angle
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			expected_angles.push_back(predict_angle(s_axis_tdata));
			void'(pending_pairs.pop_front());
		end
	end

	// Offer items from the queue at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (pending_pairs.size() > 0 && (calm || $urandom_range(0, 99) >= 37)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pending_pairs[0];
			end else begin
				s_axis_tvalid <= 1'b0;
			end
			if (hold_off > 0) begin
				m_axis_tready <= 1'b0;
				hold_off <= hold_off - 1;
			end else begin
				m_axis_tready <= calm || $urandom_range(0, 99) >= 37;
			end
		end
	end

	// Check each result against the oldest prediction
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_angles.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected angle %0d", $signed(m_axis_tdata));
			end else begin
				if (m_axis_tdata !== expected_angles[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("angle mismatch: expected %0d actual %0d",
							$signed(expected_angles[0]), $signed(m_axis_tdata));
				end
				void'(expected_angles.pop_front());
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [15:0] corner[8];
		corner = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000,
			16'h0005, 16'hfffb, 16'h1234};
		// directed: corners crossed, zero pairs, equal magnitudes
		for (int i = 0; i < 5; i++)
			for (int j = 0; j < 5; j++)
				pending_pairs.push_back({corner[j], corner[i]});
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		wait (pending_pairs.size() == 0);
		// long stall while the sender keeps offering
		hold_off = 200;
		for (int n = 0; n < 1600; n++) begin
			logic [15:0] y, x;
			y = rand_coord();
			x = $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? y : -y) : rand_coord();
			pending_pairs.push_back({x, y});
		end
		// a stretch with no idling on either side
		wait (pending_pairs.size() <= 800);
		calm = 1;
		repeat (300) @(posedge clk);
		calm = 0;
		wait (pending_pairs.size() == 0 && !s_axis_tvalid);
		wait (expected_angles.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_angles.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

### sim.f
rtl/atp_pkg.sv
rtl/atp_div.sv
rtl/atp_mac.sv
rtl/atan2_polynomial_approx.sv
tb/atan2_polynomial_approx_tb.sv
